// ===== rtl/core/tilt_compensated_compass_heading_macros.svh =====
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading_macros.svh
// assertion shorthands used by the compass heading checker
// ----------------------------------------------------------------------------
`ifndef TILT_COMPENSATED_COMPASS_HEADING_MACROS_SVH
`define TILT_COMPENSATED_COMPASS_HEADING_MACROS_SVH

// same-cycle implication, quiet during reset
`define TCCH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define TCCH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tcch_pkg.sv =====
// ----------------------------------------------------------------------------
// tcch_pkg
// shared constants, types and arctangent table of the compass heading core
// ----------------------------------------------------------------------------
package tcch_pkg;

    // fixed-point formats
    localparam int GUARD_BITS = 8;
    localparam int ZW         = 18;
    localparam int DECL_W     = 12;
    localparam int HEAD_W     = 9;
    localparam int TENTH_W    = 12;
    localparam int RAW_W      = 14;
    localparam int GAIN_W     = 18;
    localparam int TPR_W      = 22;
    localparam int RECIP_W    = 13;

    typedef logic signed [ZW-1:0] angle_t;

    localparam angle_t                    HALF_PI_Q14        = 18'sd25736;
    localparam logic signed [GAIN_W-1:0]  INV_GAIN_Q16       = 18'sd39797;
    localparam logic signed [TPR_W-1:0]   TENTHS_PER_RAD_Q24 = 22'sd586709;
    localparam logic signed [RAW_W-1:0]   FULL_TURN_TENTHS   = 14'sd3600;
    localparam logic signed [DECL_W-1:0]  DECL_RESET         = 12'sd45;
    localparam logic [RECIP_W-1:0]        RECIP_TEN_Q16      = 13'd6554;

    // atan(2^-i) in q4.14 radians
    localparam angle_t ATAN_TAB [24] = '{
        18'sd12868, 18'sd7596, 18'sd4014, 18'sd2037, 18'sd1023, 18'sd512,
        18'sd256,   18'sd128,  18'sd64,   18'sd32,   18'sd16,   18'sd8,
        18'sd4,     18'sd2,    18'sd1,    18'sd0,    18'sd0,    18'sd0,
        18'sd0,     18'sd0,    18'sd0,    18'sd0,    18'sd0,    18'sd0
    };

endpackage

// ===== rtl/core/tcch_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// tcch_sqrt_cell
// one bit of a pipelined floor square root, carries side data along
// ----------------------------------------------------------------------------
module tcch_sqrt_cell #(
    parameter int SB     = 16,
    parameter int K      = 0,
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                en,
    input  logic [2*SB-1:0]     rem_in,
    input  logic [SB-1:0]       root_in,
    input  logic [SIDE_W-1:0]   side_in,
    output logic [2*SB-1:0]     rem_out,
    output logic [SB-1:0]       root_out,
    output logic [SIDE_W-1:0]   side_out
);
    localparam int TW = 2 * SB + 1;

    logic [TW-1:0]     trial;
    logic [TW-1:0]     rem_ext;
    logic [TW-1:0]     diff;
    logic              fits;
    logic [2*SB-1:0]   rem_next;
    logic [SB-1:0]     root_next;
    logic [2*SB-1:0]   rem_reg;
    logic [SB-1:0]     root_reg;
    logic [SIDE_W-1:0] side_reg;

    // try setting root bit k: rem - (root << (k+1)) - 4^k
    always_comb
    begin
        trial     = (TW'(root_in) << (K + 1)) | (TW'(1) << (2 * K));
        rem_ext   = {1'b0, rem_in};
        diff      = rem_ext - trial;
        fits      = (rem_ext >= trial);
        rem_next  = fits ? diff[2*SB-1:0] : rem_in;
        root_next = fits ? (root_in | (SB'(1) << K)) : root_in;
    end

    // stage register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;
endmodule

// ===== rtl/core/tcch_quadrant_cell.sv =====
// ----------------------------------------------------------------------------
// tcch_quadrant_cell
// quarter-turn pre-rotation ahead of a cordic chain, registered
// ----------------------------------------------------------------------------
module tcch_quadrant_cell #(
    parameter int VW     = 28,
    parameter bit ROTATE = 1'b0,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [VW-1:0] x_in,
    input  logic signed [VW-1:0] y_in,
    input  tcch_pkg::angle_t     z_in,
    input  logic [SIDE_W-1:0]    side_in,
    output logic signed [VW-1:0] x_out,
    output logic signed [VW-1:0] y_out,
    output tcch_pkg::angle_t     z_out,
    output logic [SIDE_W-1:0]    side_out
);
    import tcch_pkg::*;

    logic signed [VW-1:0] x_next;
    logic signed [VW-1:0] y_next;
    angle_t               z_next;
    logic signed [VW-1:0] x_reg;
    logic signed [VW-1:0] y_reg;
    angle_t               z_reg;
    logic [SIDE_W-1:0]    side_reg;

    // bring the vector or the angle into the right half plane
    always_comb
    begin
        x_next = x_in;
        y_next = y_in;
        z_next = z_in;
        if (ROTATE)
        begin
            if (z_in > HALF_PI_Q14)
            begin
                x_next = -y_in;
                y_next = x_in;
                z_next = z_in - HALF_PI_Q14;
            end
            else if (z_in < -HALF_PI_Q14)
            begin
                x_next = y_in;
                y_next = -x_in;
                z_next = z_in + HALF_PI_Q14;
            end
        end
        else if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                x_next = y_in;
                y_next = -x_in;
                z_next = HALF_PI_Q14;
            end
            else
            begin
                x_next = -y_in;
                y_next = x_in;
                z_next = -HALF_PI_Q14;
            end
        end
    end

    // stage register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign side_out = side_reg;
endmodule

// ===== rtl/core/tcch_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// tcch_cordic_cell
// one micro-rotation of a cordic chain, vectoring or rotation mode
// ----------------------------------------------------------------------------
module tcch_cordic_cell #(
    parameter int VW     = 28,
    parameter int STAGE  = 0,
    parameter bit ROTATE = 1'b0,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [VW-1:0] x_in,
    input  logic signed [VW-1:0] y_in,
    input  tcch_pkg::angle_t     z_in,
    input  logic [SIDE_W-1:0]    side_in,
    output logic signed [VW-1:0] x_out,
    output logic signed [VW-1:0] y_out,
    output tcch_pkg::angle_t     z_out,
    output logic [SIDE_W-1:0]    side_out
);
    import tcch_pkg::*;

    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;
    logic                 toward;
    logic signed [VW-1:0] x_next;
    logic signed [VW-1:0] y_next;
    angle_t               z_next;
    logic signed [VW-1:0] x_reg;
    logic signed [VW-1:0] y_reg;
    angle_t               z_reg;
    logic [SIDE_W-1:0]    side_reg;

    // direction from the residual angle or from the sign of y
    always_comb
    begin
        dx     = y_in >>> STAGE;
        dy     = x_in >>> STAGE;
        toward = ROTATE ? z_in[ZW-1] : !y_in[VW-1];
        if (toward)
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN_TAB[STAGE];
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN_TAB[STAGE];
        end
    end

    // stage register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign side_out = side_reg;
endmodule

// ===== rtl/core/tilt_compensated_compass_heading.sv =====
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading
// tilt-compensated compass heading from accelerometer and magnetometer items
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one item of three accelerometer
// and three magnetometer axes. Output channel: out_valid / out_stall carry
// heading_deg, whole degrees 0..359. Configuration: cfg_valid / cfg_ready
// writes declination_tenths, which is always ready; write it while idle.
// The pipeline holds squares, a bit-per-cell square root, chains of cordic
// cells (pitch and roll vectoring side by side, roll rotation, pitch
// rotation, heading vectoring), two gain corrections and the degree
// conversion. Every cell advances together.
// Throughput is one item per cycle while in_stall is low.
// A two-entry output buffer lets the pipeline run on while a result waits;
// when both entries are full the whole pipeline holds and in_stall rises
// until the receiver takes a result.
// Reset empties the pipeline and the output buffer and sets the
// declination to 4.5 degrees.
// ----------------------------------------------------------------------------
module tilt_compensated_compass_heading #(
    parameter int CORDIC_STAGES = 16,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [SAMPLE_BITS-1:0]        accel_x,
    input  logic signed [SAMPLE_BITS-1:0]        accel_y,
    input  logic signed [SAMPLE_BITS-1:0]        accel_z,
    input  logic signed [SAMPLE_BITS-1:0]        mag_x,
    input  logic signed [SAMPLE_BITS-1:0]        mag_y,
    input  logic signed [SAMPLE_BITS-1:0]        mag_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tcch_pkg::HEAD_W-1:0]          heading_deg,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic signed [tcch_pkg::DECL_W-1:0]   declination_tenths
);
    import tcch_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int ST  = CORDIC_STAGES;
    localparam int VW  = SB + GUARD_BITS + 4;
    localparam int SQW = 2 * SB;
    localparam int PW  = VW + GAIN_W;
    localparam int JW  = ZW + TPR_W;
    localparam int DW  = TENTH_W + RECIP_W;
    localparam int LAT = 12 + SB + 4 * ST;
    localparam int PSW = SB + 3 * VW;
    localparam int PVW = 1 + 3 * VW;
    localparam int RRW = ZW + VW;

    // pipeline enable and valid chain
    logic           en;
    logic [LAT-1:0] vld_reg;

    // configuration
    logic signed [DECL_W-1:0] decl_reg;

    // stage a: input samples, magnetometer scaled, x and y flipped
    logic signed [SB-1:0] a_ax_reg, a_ay_reg, a_az_reg;
    logic signed [VW-1:0] a_mx_reg, a_my_reg, a_mz_reg;

    // stage b: squares
    logic signed [SQW-1:0] sq_ax, sq_ay, sq_az;
    logic [SQW-1:0]        b_axx_reg, b_ayy_reg, b_azz_reg;
    logic signed [SB-1:0]  b_ax_reg, b_ay_reg;
    logic signed [VW-1:0]  b_mx_reg, b_my_reg, b_mz_reg;

    // stage c: sums of squares
    logic [SQW-1:0]        c_sp_reg, c_sr_reg;
    logic signed [SB-1:0]  c_ax_reg, c_ay_reg;
    logic signed [VW-1:0]  c_mx_reg, c_my_reg, c_mz_reg;

    // square root lanes
    logic [SQW-1:0] sp_rem  [SB+1];
    logic [SQW-1:0] sr_rem  [SB+1];
    logic [SB-1:0]  sp_root [SB+1];
    logic [SB-1:0]  sr_root [SB+1];
    logic [PSW-1:0] sp_side [SB+1];
    logic [SB-1:0]  sr_side [SB+1];

    // pitch and roll vectoring
    logic signed [SB-1:0] d_ax, d_ay;
    logic signed [VW-1:0] d_mx, d_my, d_mz;
    logic signed [VW-1:0] d_px, d_py, d_rx, d_ry;
    logic                 d_pzero, d_rzero;
    logic signed [VW-1:0] pv_x [ST+1], pv_y [ST+1];
    angle_t               pv_z [ST+1];
    logic [PVW-1:0]       pv_s [ST+1];
    logic signed [VW-1:0] rv_x [ST+1], rv_y [ST+1];
    angle_t               rv_z [ST+1];
    logic                 rv_s [ST+1];

    // roll rotation of (my, mz)
    logic                 e_pzero;
    logic signed [VW-1:0] e_mx, e_my, e_mz;
    angle_t               e_pitch, e_roll;
    logic signed [VW-1:0] rr_x [ST+1], rr_y [ST+1];
    angle_t               rr_z [ST+1];
    logic [RRW-1:0]       rr_s [ST+1];

    // stage f: roll gain correction
    logic signed [PW-1:0] f_yh_prod, f_tz_prod;
    logic signed [PW-1:0] f_yh_reg, f_tz_reg;
    angle_t               f_pitch_reg;
    logic signed [VW-1:0] f_mx_reg;

    // pitch rotation of (mx, tz)
    logic signed [VW-1:0] g_yh, g_tz;
    angle_t               g_npitch;
    logic signed [VW-1:0] pr_x [ST+1], pr_y [ST+1];
    angle_t               pr_z [ST+1];
    logic [VW-1:0]        pr_s [ST+1];

    // stage h: pitch gain correction
    logic signed [PW-1:0] h_xh_prod;
    logic signed [PW-1:0] h_xh_reg;
    logic signed [VW-1:0] h_yh_reg;

    // heading vectoring
    logic signed [VW-1:0] i_xh;
    logic                 i_zero;
    logic signed [VW-1:0] hv_x [ST+1], hv_y [ST+1];
    angle_t               hv_z [ST+1];
    logic                 hv_s [ST+1];

    // degree conversion and wrap
    angle_t                   j_ang;
    logic signed [JW-1:0]     j_prod;
    logic signed [JW-1:0]     j_prod_reg;
    logic signed [RAW_W-1:0]  k_raw, k_w1, k_w2;
    logic [TENTH_W-1:0]       k_t_reg;
    logic [DW-1:0]            l_div;
    logic [HEAD_W-1:0]        l_head_reg;

    // output buffer
    logic              out_valid_reg, skid_valid_reg;
    logic [HEAD_W-1:0] out_head_reg, skid_head_reg;
    logic              pop;

    assign en        = !skid_valid_reg;
    assign in_stall  = skid_valid_reg;
    assign cfg_ready = 1'b1;

    // declination register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            decl_reg <= DECL_RESET;
        else if (cfg_valid)
            decl_reg <= declination_tenths;
    end

    // valid chain follows the data cells
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // stages a to c: capture, square, sum
    always_comb
    begin
        sq_ax = a_ax_reg * a_ax_reg;
        sq_ay = a_ay_reg * a_ay_reg;
        sq_az = a_az_reg * a_az_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ax_reg  <= accel_x;
            a_ay_reg  <= accel_y;
            a_az_reg  <= accel_z;
            a_mx_reg  <= -(VW'(mag_x) <<< GUARD_BITS);
            a_my_reg  <= -(VW'(mag_y) <<< GUARD_BITS);
            a_mz_reg  <= VW'(mag_z) <<< GUARD_BITS;
            b_axx_reg <= unsigned'(sq_ax);
            b_ayy_reg <= unsigned'(sq_ay);
            b_azz_reg <= unsigned'(sq_az);
            b_ax_reg  <= a_ax_reg;
            b_ay_reg  <= a_ay_reg;
            b_mx_reg  <= a_mx_reg;
            b_my_reg  <= a_my_reg;
            b_mz_reg  <= a_mz_reg;
            c_sp_reg  <= b_azz_reg + b_ayy_reg;
            c_sr_reg  <= b_azz_reg + b_axx_reg;
            c_ax_reg  <= b_ax_reg;
            c_ay_reg  <= b_ay_reg;
            c_mx_reg  <= b_mx_reg;
            c_my_reg  <= b_my_reg;
            c_mz_reg  <= b_mz_reg;
        end
    end

    // square root cells, most significant root bit first
    assign sp_rem[0]  = c_sp_reg;
    assign sp_root[0] = '0;
    assign sp_side[0] = {c_ax_reg, c_mx_reg, c_my_reg, c_mz_reg};
    assign sr_rem[0]  = c_sr_reg;
    assign sr_root[0] = '0;
    assign sr_side[0] = c_ay_reg;

    for (genvar j = 0; j < SB; j++)
    begin : g_sqrt
        tcch_sqrt_cell #(.SB(SB), .K(SB - 1 - j), .SIDE_W(PSW)) u_sp (
            .clk(clk), .en(en),
            .rem_in(sp_rem[j]), .root_in(sp_root[j]), .side_in(sp_side[j]),
            .rem_out(sp_rem[j+1]), .root_out(sp_root[j+1]), .side_out(sp_side[j+1])
        );
        tcch_sqrt_cell #(.SB(SB), .K(SB - 1 - j), .SIDE_W(SB)) u_sr (
            .clk(clk), .en(en),
            .rem_in(sr_rem[j]), .root_in(sr_root[j]), .side_in(sr_side[j]),
            .rem_out(sr_rem[j+1]), .root_out(sr_root[j+1]), .side_out(sr_side[j+1])
        );
    end

    // pitch and roll vectors: (root, -ax) and (root, ay)
    always_comb
    begin
        {d_ax, d_mx, d_my, d_mz} = sp_side[SB];
        d_ay    = sr_side[SB];
        d_px    = VW'({1'b0, sp_root[SB]}) <<< GUARD_BITS;
        d_py    = -(VW'(d_ax) <<< GUARD_BITS);
        d_rx    = VW'({1'b0, sr_root[SB]}) <<< GUARD_BITS;
        d_ry    = VW'(d_ay) <<< GUARD_BITS;
        d_pzero = (d_px == '0) && (d_py == '0);
        d_rzero = (d_rx == '0) && (d_ry == '0);
    end

    tcch_quadrant_cell #(.VW(VW), .ROTATE(1'b0), .SIDE_W(PVW)) u_pv_q (
        .clk(clk), .en(en), .x_in(d_px), .y_in(d_py), .z_in('0),
        .side_in({d_pzero, d_mx, d_my, d_mz}),
        .x_out(pv_x[0]), .y_out(pv_y[0]), .z_out(pv_z[0]), .side_out(pv_s[0])
    );
    tcch_quadrant_cell #(.VW(VW), .ROTATE(1'b0), .SIDE_W(1)) u_rv_q (
        .clk(clk), .en(en), .x_in(d_rx), .y_in(d_ry), .z_in('0),
        .side_in(d_rzero),
        .x_out(rv_x[0]), .y_out(rv_y[0]), .z_out(rv_z[0]), .side_out(rv_s[0])
    );

    for (genvar j = 0; j < ST; j++)
    begin : g_tilt
        tcch_cordic_cell #(.VW(VW), .STAGE(j), .ROTATE(1'b0), .SIDE_W(PVW)) u_pv (
            .clk(clk), .en(en),
            .x_in(pv_x[j]), .y_in(pv_y[j]), .z_in(pv_z[j]), .side_in(pv_s[j]),
            .x_out(pv_x[j+1]), .y_out(pv_y[j+1]), .z_out(pv_z[j+1]),
            .side_out(pv_s[j+1])
        );
        tcch_cordic_cell #(.VW(VW), .STAGE(j), .ROTATE(1'b0), .SIDE_W(1)) u_rv (
            .clk(clk), .en(en),
            .x_in(rv_x[j]), .y_in(rv_y[j]), .z_in(rv_z[j]), .side_in(rv_s[j]),
            .x_out(rv_x[j+1]), .y_out(rv_y[j+1]), .z_out(rv_z[j+1]),
            .side_out(rv_s[j+1])
        );
    end

    // zero vectors give zero tilt; rotate (my, mz) by roll
    always_comb
    begin
        {e_pzero, e_mx, e_my, e_mz} = pv_s[ST];
        e_pitch = e_pzero ? '0 : pv_z[ST];
        e_roll  = rv_s[ST] ? '0 : rv_z[ST];
    end

    tcch_quadrant_cell #(.VW(VW), .ROTATE(1'b1), .SIDE_W(RRW)) u_rr_q (
        .clk(clk), .en(en), .x_in(e_my), .y_in(e_mz), .z_in(e_roll),
        .side_in({e_pitch, e_mx}),
        .x_out(rr_x[0]), .y_out(rr_y[0]), .z_out(rr_z[0]), .side_out(rr_s[0])
    );

    for (genvar j = 0; j < ST; j++)
    begin : g_roll
        tcch_cordic_cell #(.VW(VW), .STAGE(j), .ROTATE(1'b1), .SIDE_W(RRW)) u_rr (
            .clk(clk), .en(en),
            .x_in(rr_x[j]), .y_in(rr_y[j]), .z_in(rr_z[j]), .side_in(rr_s[j]),
            .x_out(rr_x[j+1]), .y_out(rr_y[j+1]), .z_out(rr_z[j+1]),
            .side_out(rr_s[j+1])
        );
    end

    // roll gain correction
    assign f_yh_prod = rr_x[ST] * INV_GAIN_Q16;
    assign f_tz_prod = rr_y[ST] * INV_GAIN_Q16;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_yh_reg                <= f_yh_prod;
            f_tz_reg                <= f_tz_prod;
            {f_pitch_reg, f_mx_reg} <= rr_s[ST];
        end
    end

    // rotate (mx, tz) by minus pitch
    always_comb
    begin
        g_yh     = VW'(f_yh_reg >>> 16);
        g_tz     = VW'(f_tz_reg >>> 16);
        g_npitch = -f_pitch_reg;
    end

    tcch_quadrant_cell #(.VW(VW), .ROTATE(1'b1), .SIDE_W(VW)) u_pr_q (
        .clk(clk), .en(en), .x_in(f_mx_reg), .y_in(g_tz), .z_in(g_npitch),
        .side_in(g_yh),
        .x_out(pr_x[0]), .y_out(pr_y[0]), .z_out(pr_z[0]), .side_out(pr_s[0])
    );

    for (genvar j = 0; j < ST; j++)
    begin : g_pitch
        tcch_cordic_cell #(.VW(VW), .STAGE(j), .ROTATE(1'b1), .SIDE_W(VW)) u_pr (
            .clk(clk), .en(en),
            .x_in(pr_x[j]), .y_in(pr_y[j]), .z_in(pr_z[j]), .side_in(pr_s[j]),
            .x_out(pr_x[j+1]), .y_out(pr_y[j+1]), .z_out(pr_z[j+1]),
            .side_out(pr_s[j+1])
        );
    end

    // pitch gain correction, x only
    assign h_xh_prod = pr_x[ST] * INV_GAIN_Q16;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_xh_reg <= h_xh_prod;
            h_yh_reg <= signed'(pr_s[ST]);
        end
    end

    // heading vector (xh, yh)
    always_comb
    begin
        i_xh   = VW'(h_xh_reg >>> 16);
        i_zero = (i_xh == '0) && (h_yh_reg == '0);
    end

    tcch_quadrant_cell #(.VW(VW), .ROTATE(1'b0), .SIDE_W(1)) u_hv_q (
        .clk(clk), .en(en), .x_in(i_xh), .y_in(h_yh_reg), .z_in('0),
        .side_in(i_zero),
        .x_out(hv_x[0]), .y_out(hv_y[0]), .z_out(hv_z[0]), .side_out(hv_s[0])
    );

    for (genvar j = 0; j < ST; j++)
    begin : g_head
        tcch_cordic_cell #(.VW(VW), .STAGE(j), .ROTATE(1'b0), .SIDE_W(1)) u_hv (
            .clk(clk), .en(en),
            .x_in(hv_x[j]), .y_in(hv_y[j]), .z_in(hv_z[j]), .side_in(hv_s[j]),
            .x_out(hv_x[j+1]), .y_out(hv_y[j+1]), .z_out(hv_z[j+1]),
            .side_out(hv_s[j+1])
        );
    end

    // radians to tenths, add declination, wrap, divide by ten
    always_comb
    begin
        j_ang  = hv_s[ST] ? '0 : hv_z[ST];
        j_prod = j_ang * TENTHS_PER_RAD_Q24;
        k_raw  = RAW_W'(j_prod_reg >>> 24) + RAW_W'(decl_reg);
        k_w1   = (k_raw < 0) ? k_raw + FULL_TURN_TENTHS : k_raw;
        if (k_w1 < 0)
            k_w2 = k_w1 + FULL_TURN_TENTHS;
        else if (k_w1 >= FULL_TURN_TENTHS)
            k_w2 = k_w1 - FULL_TURN_TENTHS;
        else
            k_w2 = k_w1;
        l_div  = DW'(k_t_reg) * DW'(RECIP_TEN_Q16);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j_prod_reg <= j_prod;
            k_t_reg    <= TENTH_W'(k_w2);
            l_head_reg <= l_div[DW-1:16];
        end
    end

    // two-entry output buffer
    assign pop = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
            out_valid_reg <= vld_reg[LAT-1];
        else if (vld_reg[LAT-1])
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_head_reg <= skid_head_reg;
        end
        else if (!out_valid_reg || pop)
            out_head_reg <= l_head_reg;
        else
            skid_head_reg <= l_head_reg;
    end

    assign out_valid   = out_valid_reg;
    assign heading_deg = out_head_reg;
endmodule

// ===== rtl/core/tcch_checker.sv =====
// ----------------------------------------------------------------------------
// tcch_checker
// port-level checks of the compass heading core, bound to the top level
// ----------------------------------------------------------------------------
`include "tilt_compensated_compass_heading_macros.svh"

module tcch_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [tcch_pkg::HEAD_W-1:0] heading_deg,
    input logic                        cfg_valid,
    input logic                        cfg_ready
);
    // a held result keeps its value
    `TCCH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(heading_deg), "result changed while stalled")

    // heading stays inside one turn
    `TCCH_ASSERT_NOW(a_range, out_valid, heading_deg <= 9'd359, "heading out of range")

    // input only backs up when a result is waiting
    `TCCH_ASSERT_NOW(a_stall_cause, in_stall, out_valid, "input stalled with empty output")

    // one taken result frees the input
    `TCCH_ASSERT_NEXT(a_stall_release, in_stall && !out_stall, !in_stall, "input stall not released")

    // configuration never waits
    `TCCH_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")
endmodule

bind tilt_compensated_compass_heading tcch_checker u_tcch_checker (.*);
